>>> sv/assert_macros.svh
// assertion helpers shared by the plotter modules
// each macro samples on aclk and is switched off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WCP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("waveform plotter check failed");

// next-cycle implication
`define WCP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("waveform plotter check failed");

`endif

>>> sv/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared types and fixed widths of the waveform column plotter.
// ----------------------------------------------------------------------------
package wcp_pkg;

    // fixed field widths
    localparam int PIX_W    = 7;   // output coordinate fields
    localparam int ROW_W    = 8;   // row value, covers any screen up to 256 rows
    localparam int SAMPLE_W = 16;  // signed sample taken from the raw word
    localparam int SUM_W    = 25;  // group accumulator
    localparam int SPC_W    = 8;   // samples per column register and group count
    localparam int SCL_W    = 23;  // spc * full scale
    localparam int T_W      = 29;  // signed spc*full_scale + 8*sum
    localparam int DEN_W    = 24;  // 2 * spc * full scale
    localparam int PAIR_W   = 6;   // pair counter, up to 64 pairs
    localparam int FS_SHIFT = 15;  // full scale is 2^15 - 1
    localparam int QUO_XTRA = 12;  // quotient bits above the row width

    localparam logic [SPC_W-1:0]  SPC_RESET = 8'd32;
    localparam logic [PAIR_W-1:0] PAIR_MAX  = 6'd63;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DIV,
        ST_PLOT
    } state_t;

    // stroke request from the sequencer to the pixel emitter
    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] x1;
        logic [ROW_W-1:0] y1;
        logic [PIX_W-1:0] x2;
        logic [ROW_W-1:0] y2;
    } stroke_req_t;

endpackage

>>> sv/wcp_div.sv
// ----------------------------------------------------------------------------
// wcp_div
// Iterative restoring divider: one compare/subtract per cycle, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcp_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 24,
    parameter int QW    = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QW-1:0]    quo
);

    localparam int DW    = DEN_W + QW;
    localparam int CNT_W = $clog2(QW);

    logic [NUM_W-1:0] rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW-1:0]    rem_ext;
    logic             ge;
    logic [DW-1:0]    diff;

    // shared compare and subtract
    always_comb begin
        rem_ext = DW'(rem_reg);
        ge      = rem_ext >= dvs_reg;
        diff    = rem_ext - dvs_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dvs_reg <= DW'(den) << (QW - 1);
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= NUM_W'(diff);
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `WCP_ASSERT_IMP(a_div_start_idle, start, !busy_reg)
    `WCP_ASSERT_IMP(a_div_done_idle, done_reg, !busy_reg)

endmodule

>>> sv/wcp_stroke.sv
// ----------------------------------------------------------------------------
// wcp_stroke
// Pixel pair emitter: walks two pixels toward each other, one pair per
// accepted item, from registered outputs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcp_stroke (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wcp_pkg::stroke_req_t          req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcp_pkg::PIX_W-1:0]     m_left_x,
    output logic [wcp_pkg::PIX_W-1:0]     m_left_y,
    output logic [wcp_pkg::PIX_W-1:0]     m_right_x,
    output logic [wcp_pkg::PIX_W-1:0]     m_right_y,
    output logic                          m_last_pixel
);

    logic                          valid_reg;
    logic [wcp_pkg::PAIR_W-1:0]    cnt_reg;
    logic [wcp_pkg::ROW_W-1:0]     ly_reg;
    logic [wcp_pkg::ROW_W-1:0]     ry_reg;
    logic [wcp_pkg::PIX_W-1:0]     lx_reg;
    logic [wcp_pkg::PIX_W-1:0]     rx_reg;
    logic                          down_reg;

    logic                          down;
    logic [wcp_pkg::ROW_W-1:0]     dy;
    logic [wcp_pkg::ROW_W-2:0]     half;
    logic [wcp_pkg::PAIR_W-1:0]    pairs_m1;
    logic                          take;

    // stroke length from the two end rows
    always_comb begin
        down = req.y2 < req.y1;
        dy   = down ? (req.y1 - req.y2) : (req.y2 - req.y1);
        half = dy[wcp_pkg::ROW_W-1:1];
        if (half > (wcp_pkg::ROW_W-1)'(wcp_pkg::PAIR_MAX)) begin
            pairs_m1 = wcp_pkg::PAIR_MAX;
        end else begin
            pairs_m1 = wcp_pkg::PAIR_W'(half);
        end
    end

    assign take = valid_reg && m_ready;

    // valid and pair count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (req.start) begin
            valid_reg <= 1'b1;
            cnt_reg   <= pairs_m1;
        end else if (take) begin
            if (cnt_reg == '0) begin
                valid_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // pixel positions
    always_ff @(posedge aclk) begin
        if (req.start) begin
            ly_reg   <= req.y1;
            ry_reg   <= req.y2;
            lx_reg   <= req.x1;
            rx_reg   <= req.x2;
            down_reg <= down;
        end else if (take) begin
            if (down_reg) begin
                ly_reg <= ly_reg - 1'b1;
                ry_reg <= ry_reg + 1'b1;
            end else begin
                ly_reg <= ly_reg + 1'b1;
                ry_reg <= ry_reg - 1'b1;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_left_x     = lx_reg;
    assign m_left_y     = wcp_pkg::PIX_W'(ly_reg);
    assign m_right_x    = rx_reg;
    assign m_right_y    = wcp_pkg::PIX_W'(ry_reg);
    assign m_last_pixel = (cnt_reg == '0);

    `WCP_ASSERT_IMP(a_stroke_start_idle, req.start, !valid_reg)
    `WCP_ASSERT_NXT(a_stroke_continues, take && (cnt_reg != '0), valid_reg)

endmodule

>>> sv/waveform_column_plotter.sv
// ----------------------------------------------------------------------------
// waveform_column_plotter
// Audio waveform to screen strokes: groups samples into columns, scales the
// group average to a row and emits the pixel pairs joining adjacent columns.
// ----------------------------------------------------------------------------
// A sample that does not finish an on-screen column is taken in idle, and
// s_ready stays high. A sample that finishes an on-screen column keeps
// s_ready low through row scaling (the PREP setup, the SCALE check and the
// bit-serial divider in DIV; the divider is skipped when the scaled sum is
// not positive and the row is zero), then through the pixel pairs, which
// wait while m_ready is low (|dy|/2 + 1 pairs, at most 64), and s_ready
// returns on the cycle after the last pair is taken.
// Configuration writes are always accepted and must only arrive while no
// item is in flight.
`include "assert_macros.svh"

module waveform_column_plotter #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wcp_pkg::SPC_W-1:0]     cfg_samples_per_column,
    // sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_raw_word,
    input  logic                          s_frame_start,
    // pixel pair output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcp_pkg::PIX_W-1:0]     m_left_x,
    output logic [wcp_pkg::PIX_W-1:0]     m_left_y,
    output logic [wcp_pkg::PIX_W-1:0]     m_right_x,
    output logic [wcp_pkg::PIX_W-1:0]     m_right_y,
    output logic                          m_last_pixel
);

    localparam int HB    = $clog2(SCREEN_HEIGHT);
    localparam int CW    = $clog2(SCREEN_WIDTH + 1);
    localparam int NUM_W = wcp_pkg::T_W - 1 + HB;
    localparam int QW    = HB + wcp_pkg::QUO_XTRA;

    wcp_pkg::state_t state_reg, state_next;

    logic [wcp_pkg::SPC_W-1:0]        spc_reg;
    logic signed [wcp_pkg::SUM_W-1:0] sum_reg;
    logic [wcp_pkg::SPC_W-1:0]        count_reg;
    logic [CW-1:0]                    col_reg;
    logic [wcp_pkg::PIX_W-1:0]        prev_col_reg;
    logic [wcp_pkg::PIX_W-1:0]        prev_row_reg;
    logic signed [wcp_pkg::T_W-1:0]   t_reg;
    logic [wcp_pkg::DEN_W-1:0]        den_reg;

    logic                             s_take;
    logic                             m_take_last;
    logic signed [wcp_pkg::SUM_W-1:0] sum_base;
    logic signed [wcp_pkg::SUM_W-1:0] sum_new;
    logic [wcp_pkg::SPC_W-1:0]        count_new;
    logic [CW-1:0]                    col_new;
    logic [wcp_pkg::SPC_W-1:0]        spc_eff;
    logic                             complete;
    logic                             on_screen;
    logic [wcp_pkg::SCL_W-1:0]        spc_scaled;
    logic signed [wcp_pkg::T_W-1:0]   t_next;
    logic                             t_pos;
    logic [NUM_W-1:0]                 num_val;
    logic                             div_start;
    logic                             div_done;
    logic [QW-1:0]                    quo;
    logic [QW-1:0]                    row_clamp;
    logic [wcp_pkg::ROW_W-1:0]        row_val;
    logic                             plot_fire;
    logic [wcp_pkg::PIX_W-1:0]        x_new;
    wcp_pkg::stroke_req_t             req;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spc_reg <= wcp_pkg::SPC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            spc_reg <= cfg_samples_per_column;
        end
    end

    // sample intake and group completion
    always_comb begin
        s_take    = s_valid && s_ready;
        sum_base  = s_frame_start ? '0 : sum_reg;
        sum_new   = sum_base + wcp_pkg::SUM_W'($signed(s_raw_word[31:16]));
        count_new = (s_frame_start ? '0 : count_reg) + 1'b1;
        col_new   = s_frame_start ? '0 : col_reg;
        spc_eff   = (spc_reg == '0) ? wcp_pkg::SPC_W'(1) : spc_reg;
        complete  = count_new >= spc_eff;
        on_screen = col_new < CW'(SCREEN_WIDTH);
    end

    // row scaling operands: spc*(2^15-1) + 8*sum over 2*spc*(2^15-1)
    always_comb begin
        spc_scaled = (wcp_pkg::SCL_W'(spc_eff) << wcp_pkg::FS_SHIFT)
                     - wcp_pkg::SCL_W'(spc_eff);
        t_next     = wcp_pkg::T_W'({1'b0, spc_scaled})
                     + {sum_reg[wcp_pkg::SUM_W-1], sum_reg, 3'b000};
        t_pos      = !t_reg[wcp_pkg::T_W-1] && (t_reg != '0);
        num_val    = NUM_W'(t_reg[wcp_pkg::T_W-2:0]) * NUM_W'(SCREEN_HEIGHT - 1);
    end

    // clamp the quotient to the highest row, SCREEN_HEIGHT - 1
    always_comb begin
        if (quo > QW'(SCREEN_HEIGHT - 1)) begin
            row_clamp = QW'(SCREEN_HEIGHT - 1);
        end else begin
            row_clamp = quo;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wcp_pkg::ST_IDLE: begin
                if (s_take && complete && on_screen) begin
                    state_next = wcp_pkg::ST_PREP;
                end
            end
            wcp_pkg::ST_PREP: begin
                state_next = wcp_pkg::ST_SCALE;
            end
            wcp_pkg::ST_SCALE: begin
                state_next = t_pos ? wcp_pkg::ST_DIV : wcp_pkg::ST_PLOT;
            end
            wcp_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = wcp_pkg::ST_PLOT;
                end
            end
            wcp_pkg::ST_PLOT: begin
                if (m_take_last) begin
                    state_next = wcp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wcp_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        plot_fire = 1'b0;
        row_val   = '0;
        unique case (state_reg)
            wcp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            wcp_pkg::ST_PREP: begin
            end
            wcp_pkg::ST_SCALE: begin
                div_start = t_pos;
                plot_fire = !t_pos;
            end
            wcp_pkg::ST_DIV: begin
                plot_fire = div_done;
                row_val   = wcp_pkg::ROW_W'(row_clamp);
            end
            wcp_pkg::ST_PLOT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // group accumulator and column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            count_reg    <= '0;
            col_reg      <= '0;
            prev_col_reg <= '0;
            prev_row_reg <= '0;
        end else begin
            if (s_take) begin
                col_reg <= col_new;
                if (complete && !on_screen) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else if (complete) begin
                    sum_reg   <= sum_new;
                    count_reg <= '0;
                end else begin
                    sum_reg   <= sum_new;
                    count_reg <= count_new;
                end
            end else if (state_reg == wcp_pkg::ST_PREP) begin
                sum_reg <= '0;
            end
            if (plot_fire) begin
                prev_col_reg <= x_new;
                prev_row_reg <= wcp_pkg::PIX_W'(row_val);
                col_reg      <= col_reg + 1'b1;
            end
        end
    end

    // scaling operands
    always_ff @(posedge aclk) begin
        if (state_reg == wcp_pkg::ST_PREP) begin
            t_reg   <= t_next;
            den_reg <= {spc_scaled, 1'b0};
        end
    end

    // row divider
    wcp_div #(
        .NUM_W (NUM_W),
        .DEN_W (wcp_pkg::DEN_W),
        .QW    (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_val),
        .den     (den_reg),
        .done    (div_done),
        .quo     (quo)
    );

    // stroke request: the first column of a frame joins to itself
    always_comb begin
        x_new     = wcp_pkg::PIX_W'(col_reg);
        req.start = plot_fire;
        req.x2    = x_new;
        req.y2    = row_val;
        if (col_reg == '0) begin
            req.x1 = x_new;
            req.y1 = row_val;
        end else begin
            req.x1 = prev_col_reg;
            req.y1 = wcp_pkg::ROW_W'(prev_row_reg);
        end
    end

    wcp_stroke u_stroke (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_x     (m_left_x),
        .m_left_y     (m_left_y),
        .m_right_x    (m_right_x),
        .m_right_y    (m_right_y),
        .m_last_pixel (m_last_pixel)
    );

    assign m_take_last = m_valid && m_ready && m_last_pixel;

    `WCP_ASSERT_IMP(a_no_intake_while_plotting, s_ready, !m_valid)
    `WCP_ASSERT_NXT(a_idle_after_stroke, m_take_last, s_ready)
    `WCP_ASSERT_IMP(a_plot_only_on_screen, plot_fire, col_reg < CW'(SCREEN_WIDTH))

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for waveform_column_plotter. Audio words go in through
// a queue-fed driver and pixel pairs come out through a stalling sink. Both
// sides idle in random bursts. Each pixel pair is checked in order against a
// behavioral prediction of column grouping, row scaling and stroke stepping,
// over several samples-per-column settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PIX_W         = wcp_pkg::PIX_W;
    localparam int SPC_W         = wcp_pkg::SPC_W;
    localparam logic [SPC_W-1:0] SPC_RESET = wcp_pkg::SPC_RESET;
    localparam int SCREEN_W      = 128;
    localparam int SCREEN_H      = 128;
    localparam int FULL_SCALE    = (1 << wcp_pkg::FS_SHIFT) - 1;
    localparam int MAX_PAIRS     = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [31:0] raw_word;
        logic        frame_start;
    } sample_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] left_x;
        logic [PIX_W-1:0] left_y;
        logic [PIX_W-1:0] right_x;
        logic [PIX_W-1:0] right_y;
        logic             last_pixel;
    } pixel_pair_t;

    logic               aclk                   = 1'b0;
    logic               aresetn                = 1'b0;
    logic               cfg_valid              = 1'b0;
    logic               cfg_ready;
    logic [SPC_W-1:0]   cfg_samples_per_column = '0;
    logic               s_valid                = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_raw_word             = '0;
    logic               s_frame_start          = 1'b0;
    logic               m_valid;
    logic               m_ready                = 1'b0;
    logic [PIX_W-1:0]   m_left_x;
    logic [PIX_W-1:0]   m_left_y;
    logic [PIX_W-1:0]   m_right_x;
    logic [PIX_W-1:0]   m_right_y;
    logic               m_last_pixel;

    // stimulus and scoreboard bookkeeping
    sample_item_t pending_samples[$];
    pixel_pair_t  expected_pairs[$];
    int           queued_cnt   = 0;
    int           accepted_cnt = 0;
    int           error_cnt    = 0;
    int           send_gap     = 0;
    int           sink_stall   = 0;
    int           hold_left    = 0;
    int           quiet_cycles = 0;
    bit           hold_done    = 1'b0;
    logic         hold_req     = 1'b0;
    logic         idle_en      = 1'b1;

    // predicted plotter state
    logic [SPC_W-1:0] spc_shadow = SPC_RESET;
    int               acc_sum    = 0;
    int               acc_cnt    = 0;
    int               col_idx    = 0;
    logic [PIX_W-1:0] last_col   = '0;
    logic [PIX_W-1:0] last_row   = '0;

    waveform_column_plotter #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_samples_per_column (cfg_samples_per_column),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_raw_word             (s_raw_word),
        .s_frame_start          (s_frame_start),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_left_x               (m_left_x),
        .m_left_y               (m_left_y),
        .m_right_x              (m_right_x),
        .m_right_y              (m_right_y),
        .m_last_pixel           (m_last_pixel)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // group one sample, and on a finished on-screen column queue its stroke
    function automatic void predict_stroke(input logic [31:0] word, input logic frame_start);
        int          sample_val;
        int          spc;
        int          row;
        int          x1, y1, x2, y2;
        int          dir, dy, npairs;
        longint      num, den;
        pixel_pair_t pair;
        sample_val = int'($signed(word[31:16]));
        spc        = (spc_shadow == '0) ? 1 : int'(spc_shadow);
        if (frame_start) begin
            acc_sum = 0;
            acc_cnt = 0;
            col_idx = 0;
        end
        acc_sum += sample_val;
        acc_cnt++;
        if (acc_cnt < spc)
            return;

        // row = floor((H-1) * (spc*fs + 8*sum) / (2*spc*fs)), clamped
        num = longint'(SCREEN_H - 1) * (longint'(spc) * FULL_SCALE + 8 * longint'(acc_sum));
        den = 2 * longint'(spc) * FULL_SCALE;
        if (num <= 0)
            row = 0;
        else if (num / den > SCREEN_H - 1)
            row = SCREEN_H - 1;
        else
            row = int'(num / den);
        acc_sum = 0;
        acc_cnt = 0;
        if (col_idx >= SCREEN_W)
            return;

        // first column of a frame joins to itself
        x2 = col_idx;
        y2 = row;
        x1 = (col_idx == 0) ? x2 : int'(last_col);
        y1 = (col_idx == 0) ? y2 : int'(last_row);
        if (y2 < y1) begin
            dir = -1;
            dy  = y1 - y2;
        end else begin
            dir = 1;
            dy  = y2 - y1;
        end
        npairs = dy / 2 + 1;
        if (npairs > MAX_PAIRS)
            npairs = MAX_PAIRS;
        for (int i = 0; i < npairs; i++) begin
            pair.left_x     = x1[PIX_W-1:0];
            pair.left_y     = PIX_W'(y1 + dir * i);
            pair.right_x    = x2[PIX_W-1:0];
            pair.right_y    = PIX_W'(y2 - dir * i);
            pair.last_pixel = (i + 1 == npairs);
            expected_pairs.push_back(pair);
        end
        last_col = x2[PIX_W-1:0];
        last_row = y2[PIX_W-1:0];
        col_idx++;
    endfunction

    // audio word around a level, with some fully random words mixed in
    function automatic logic [31:0] make_word(input int level);
        int s;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        s = level + int'($urandom_range(0, 1023)) - 512;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return {s[15:0], 16'($urandom)};
    endfunction

    task automatic queue_sample(input logic [31:0] word, input logic frame_start);
        queued_cnt++;
        pending_samples.push_back(sample_item_t'{raw_word: word, frame_start: frame_start});
    endtask

    // n samples, a new level per group, occasional stray frame starts
    task automatic queue_frame(input int n, input int spc, input bit first_fs,
                               input int fs_pct);
        int level;
        level = 0;
        for (int k = 0; k < n; k++) begin
            if (k % spc == 0)
                level = int'($urandom_range(0, 20000)) - 10000;
            queue_sample(make_word(level),
                         (k == 0) ? first_fs : ($urandom_range(0, 99) < fs_pct));
        end
    endtask

    // all items taken, all pairs seen, then let the block go idle
    task automatic wait_drained();
        do @(negedge aclk);
        while (accepted_cnt != queued_cnt || expected_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_spc(input logic [SPC_W-1:0] value);
        @(posedge aclk);
        cfg_samples_per_column <= value;
        cfg_valid              <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // sample driver: holds an offered item, else idles or pops the next one
    always @(posedge aclk) begin : sample_driver
        sample_item_t nxt;
        logic         offer;
        offer = s_valid && !s_ready;
        if (aresetn && !offer) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 18) - 1;
            end else if (pending_samples.size() > 0) begin
                nxt = pending_samples.pop_front();
                s_raw_word    <= nxt.raw_word;
                s_frame_start <= nxt.frame_start;
                offer = 1'b1;
            end
        end
        s_valid <= offer;
    end

    // pixel sink: one long hold-off on request, otherwise random stall bursts
    always @(posedge aclk) begin : pixel_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: track config, predict on accepted items, check pixel pairs
    always @(posedge aclk) begin : pair_monitor
        pixel_pair_t got;
        pixel_pair_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                spc_shadow = cfg_samples_per_column;
            if (s_valid && s_ready) begin
                accepted_cnt++;
                predict_stroke(s_raw_word, s_frame_start);
            end
            if (m_valid && m_ready) begin
                got = '{m_left_x, m_left_y, m_right_x, m_right_y, m_last_pixel};
                if (expected_pairs.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("unexpected pixel pair (%0d,%0d)-(%0d,%0d) last %0b",
                                 got.left_x, got.left_y, got.right_x, got.right_y,
                                 got.last_pixel);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got != want) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $write("pixel pair mismatch: expected (%0d,%0d)-(%0d,%0d) last %0b",
                                   want.left_x, want.left_y, want.right_x,
                                   want.right_y, want.last_pixel);
                            $display(", got (%0d,%0d)-(%0d,%0d) last %0b",
                                     got.left_x, got.left_y, got.right_x,
                                     got.right_y, got.last_pixel);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int spc_pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: one column per sample, field extremes and row edges
        write_spc(8'd1);
        queue_sample(32'h7FFF_0000, 1'b1);  // top row, first column joins itself
        queue_sample(32'h8000_0000, 1'b0);  // bottom row, longest stroke at 64 pairs
        queue_sample(32'h7FFF_FFFF, 1'b0);  // back to the top
        queue_sample(32'h1000_0000, 1'b0);  // just saturates, flat stroke
        queue_sample(32'h0FFF_0000, 1'b0);  // one row below the top
        queue_sample(32'hF000_0000, 1'b0);  // numerator just negative
        queue_sample(32'hF001_0000, 1'b0);  // rounds down to row zero
        queue_sample(32'h0000_FFFF, 1'b0);  // midscale, low half ignored
        queue_sample(32'hFFFF_0000, 1'b0);
        queue_sample(32'h0021_0000, 1'b0);  // one row above midscale
        queue_sample(32'h0001_0000, 1'b0);
        queue_sample(32'h5555_AAAA, 1'b1);  // new frame mid-stream
        queue_sample(32'hAAAA_5555, 1'b0);
        queue_sample(32'h0400_0000, 1'b0);
        queue_sample(32'h0000_0000, 1'b1);
        wait_drained();

        // wider grouping, leaves a partial group behind
        write_spc(8'd9);
        queue_frame(21, 9, 1'b1, 0);
        wait_drained();

        // lowered setting completes the partial group on the next sample
        write_spc(8'd2);
        queue_frame(8, 2, 1'b0, 3);
        wait_drained();

        // zero setting acts as one, with noisy frame starts
        write_spc(8'd0);
        queue_frame(8, 1, 1'b1, 10);
        wait_drained();

        // sink holds off early on while the sender keeps offering
        write_spc(8'd1);
        queue_frame(20, 1, 1'b1, 0);
        @(posedge aclk);
        hold_req <= 1'b1;
        wait_drained();

        repeat (2) begin
            spc_pick = $urandom_range(1, 4);
            write_spc(spc_pick[SPC_W-1:0]);
            queue_frame(8, spc_pick, 1'($urandom_range(0, 1)), 5);
            wait_drained();
        end

        // closing stretch at full rate on both sides
        idle_en <= 1'b0;
        write_spc(8'd3);
        queue_frame(12, 3, 1'b1, 2);
        wait_drained();

        if (error_cnt == 0 && expected_pairs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
